// ===== rtl/gps_pkg.sv =====
// Shared types and constants of the gradient point selector.
`default_nettype none

package gps_pkg;

  localparam int PIX_W   = 8;
  localparam int COL_W   = 12;   // column as carried in the queue, covers the longest line
  localparam int ROW_W   = 12;
  localparam int ROWX_W  = ROW_W + 1;
  localparam int OCOL_W  = 10;

  localparam int IW_W    = 11;
  localparam int IH_W    = 12;
  localparam int BM_W    = 7;
  localparam int TH_W    = 17;
  localparam int CF_W    = 18;
  localparam int OFS_W   = 16;

  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 18;

  localparam int SQ_W    = 17;
  localparam int DP_W    = 18;
  localparam int PROD_W  = CF_W + DP_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int SON_W   = 32;

  localparam int OUT_W   = OCOL_W + ROW_W + PIX_W + 2 * SON_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef enum logic [CFG_AW-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_BORDER       = 3'd2,
    CFG_THRESH       = 3'd3,
    CFG_COEF_COS     = 3'd4,
    CFG_COEF_SIN     = 3'd5,
    CFG_OFFSET_X     = 3'd6,
    CFG_OFFSET_Y     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic        [IW_W-1:0]  image_width;
    logic        [IH_W-1:0]  image_height;
    logic        [BM_W-1:0]  border_margin;
    logic        [TH_W-1:0]  grad_thresh_sq;
    logic signed [CF_W-1:0]  coef_cos;
    logic signed [CF_W-1:0]  coef_sin;
    logic        [OFS_W-1:0] offset_x;
    logic        [OFS_W-1:0] offset_y;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    image_width:    11'd640,
    image_height:   12'd480,
    border_margin:  7'd10,
    grad_thresh_sq: 17'd10000,
    coef_cos:       18'sd0,
    coef_sin:       -18'sd1311,
    offset_x:       16'd5120,
    offset_y:       16'd7680
  };

  // candidate pixel handed from front to back
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [PIX_W-1:0] gray;
    logic [PIX_W-1:0] below;
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] right;
  } cand_t;

endpackage

`default_nettype wire

// ===== rtl/gps_front.sv =====
// Front end: raster counters, line buffers with bypass, window test, candidate push.
`default_nettype none

module gps_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gps_pkg::cfg_t               cfg_i,
  input  logic                        s_valid_i,
  output logic                        s_ready_o,
  input  logic [gps_pkg::PIX_W-1:0]   s_pix_i,
  input  logic                        s_fs_i,
  output logic                        q_push_o,
  output gps_pkg::cand_t              q_data_o,
  input  logic                        q_full_i,
  output logic                        clear_busy_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  // holds the configured width and column plus margin
  localparam int XW = $clog2(MAX_WIDTH + 2176);

  logic [gps_pkg::PIX_W-1:0] lc_mem [MAX_WIDTH];
  logic [gps_pkg::PIX_W-1:0] lp_mem [MAX_WIDTH];

  logic                        clr_q;
  logic [CW-1:0]               clr_addr_q;
  logic [CW-1:0]               col_q, col_d;
  logic [gps_pkg::ROW_W-1:0]   row_q, row_d;

  logic                        s1_v_q;
  logic [CW-1:0]               s1_c_q;
  logic [gps_pkg::ROW_W-1:0]   s1_row_q;
  logic [gps_pkg::PIX_W-1:0]   s1_pix_q, s1_cur_q, s1_above_q, s1_right_q, s1_left_q;
  logic [gps_pkg::PIX_W-1:0]   last_cur_q;

  logic [XW-1:0]               w_eff, c_base, c_cur, c_nxt;
  logic [gps_pkg::ROW_W-1:0]   h_eff, r_base;
  logic [gps_pkg::ROWX_W-1:0]  r_nxt;
  logic [gps_pkg::BM_W-1:0]    m_eff;
  logic [CW-1:0]               rd_addr, rd_addr_r;
  logic                        accept, s1_adv, in_win, fwd_c, fwd_r;
  logic                        mem_we;
  logic [CW-1:0]               mem_wa;
  logic [gps_pkg::PIX_W-1:0]   wd_c, wd_p;

  // effective geometry
  always_comb begin
    if (cfg_i.image_width == '0) begin
      w_eff = XW'(1);
    end else if (XW'(cfg_i.image_width) > XW'(MAX_WIDTH)) begin
      w_eff = XW'(MAX_WIDTH);
    end else begin
      w_eff = XW'(cfg_i.image_width);
    end
    h_eff = (cfg_i.image_height == '0) ? gps_pkg::ROW_W'(1) : cfg_i.image_height;
    m_eff = (cfg_i.border_margin == '0) ? gps_pkg::BM_W'(1) : cfg_i.border_margin;
  end

  // raster position of the incoming word
  always_comb begin
    c_base    = s_fs_i ? '0 : XW'(col_q);
    r_base    = s_fs_i ? '0 : row_q;
    c_cur     = (c_base >= w_eff) ? '0 : c_base;
    c_nxt     = c_cur + XW'(1);
    r_nxt     = gps_pkg::ROWX_W'(r_base) + gps_pkg::ROWX_W'(1);
    rd_addr   = c_cur[CW-1:0];
    rd_addr_r = rd_addr + CW'(1);
    if (c_nxt >= w_eff) begin
      col_d = '0;
      row_d = (r_nxt >= gps_pkg::ROWX_W'(h_eff)) ? '0 : r_nxt[gps_pkg::ROW_W-1:0];
    end else begin
      col_d = c_nxt[CW-1:0];
      row_d = r_base;
    end
  end

  // window test on the held candidate (row held is one below the candidate)
  always_comb begin
    in_win = (gps_pkg::ROWX_W'(s1_row_q) >= gps_pkg::ROWX_W'(m_eff) + gps_pkg::ROWX_W'(1))
          && (gps_pkg::ROWX_W'(s1_row_q) + gps_pkg::ROWX_W'(m_eff) <= gps_pkg::ROWX_W'(h_eff))
          && (XW'(s1_c_q) >= XW'(m_eff))
          && (XW'(s1_c_q) + XW'(m_eff) < w_eff);
  end

  assign s1_adv    = s1_v_q && (!in_win || !q_full_i);
  assign s_ready_o = !clr_q && (!s1_v_q || s1_adv);
  assign accept    = s_valid_i && s_ready_o;

  // the held word writes back on the same edge that the new word reads
  assign fwd_c = s1_v_q && (s1_c_q == rd_addr);
  assign fwd_r = s1_v_q && (s1_c_q == rd_addr_r);

  assign mem_we = clr_q || s1_adv;
  assign mem_wa = clr_q ? clr_addr_q : s1_c_q;
  assign wd_c   = clr_q ? '0 : s1_pix_q;
  assign wd_p   = clr_q ? '0 : s1_cur_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      lc_mem[mem_wa] <= wd_c;
      lp_mem[mem_wa] <= wd_p;
    end
    if (accept) begin
      s1_cur_q   <= fwd_c ? s1_pix_q : lc_mem[rd_addr];
      s1_above_q <= fwd_c ? s1_cur_q : lp_mem[rd_addr];
      s1_right_q <= fwd_r ? s1_pix_q : lc_mem[rd_addr_r];
      s1_left_q  <= s1_v_q ? s1_cur_q : last_cur_q;
      s1_pix_q   <= s_pix_i;
      s1_c_q     <= rd_addr;
      s1_row_q   <= r_base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      col_q      <= '0;
      row_q      <= '0;
      s1_v_q     <= 1'b0;
      last_cur_q <= '0;
    end else begin
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + CW'(1);
        if (clr_addr_q == CW'(MAX_WIDTH - 1)) begin
          clr_q <= 1'b0;
        end
      end
      if (accept) begin
        col_q  <= col_d;
        row_q  <= row_d;
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        last_cur_q <= s1_cur_q;
      end
    end
  end

  assign q_push_o       = s1_v_q && in_win && !q_full_i;
  assign q_data_o.col   = gps_pkg::COL_W'(s1_c_q);
  assign q_data_o.row   = s1_row_q - gps_pkg::ROW_W'(1);
  assign q_data_o.gray  = s1_cur_q;
  assign q_data_o.below = s1_pix_q;
  assign q_data_o.above = s1_above_q;
  assign q_data_o.left  = s1_left_q;
  assign q_data_o.right = s1_right_q;
  assign clear_busy_o   = clr_q;

endmodule

`default_nettype wire

// ===== rtl/gps_queue.sv =====
// Short candidate queue between front and back.
`default_nettype none

module gps_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  gps_pkg::cand_t  data_i,
  output logic            full_o,
  output logic            valid_o,
  output gps_pkg::cand_t  data_o,
  input  logic            pop_i
);

  gps_pkg::cand_t             mem_q [gps_pkg::Q_DEPTH];
  logic [gps_pkg::Q_AW-1:0]   wp_q, rp_q;
  logic [gps_pkg::Q_AW:0]     cnt_q;

  assign full_o  = (cnt_q == (gps_pkg::Q_AW + 1)'(gps_pkg::Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= wp_q + gps_pkg::Q_AW'(1);
      end
      if (pop_i) begin
        rp_q <= rp_q + gps_pkg::Q_AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (gps_pkg::Q_AW + 1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (gps_pkg::Q_AW + 1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gps_back.sv =====
// Back end: gradient threshold, sonar-plane mapping, rounding and the output register.
`default_nettype none

module gps_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gps_pkg::cfg_t                     cfg_i,
  input  logic                              q_valid_i,
  input  gps_pkg::cand_t                    q_data_i,
  output logic                              q_pop_o,
  output logic                              m_valid_o,
  input  logic                              m_ready_i,
  output logic [gps_pkg::OUT_TDATA_W-1:0]   m_data_o
);

  function automatic logic [gps_pkg::SON_W-1:0] rnd_sat(
    input logic signed [gps_pkg::SUM_W-1:0] v
  );
    logic [gps_pkg::SUM_W:0]   t;
    logic [gps_pkg::SUM_W-4:0] q;
    // floor((v + 8) / 16): round half up to Q.16
    t = (gps_pkg::SUM_W + 1)'(v) + (gps_pkg::SUM_W + 1)'(8);
    q = t[gps_pkg::SUM_W:4];
    if (q[gps_pkg::SUM_W-4:gps_pkg::SON_W-1] == '0 ||
        q[gps_pkg::SUM_W-4:gps_pkg::SON_W-1] == '1) begin
      rnd_sat = q[gps_pkg::SON_W-1:0];
    end else if (q[gps_pkg::SUM_W-4]) begin
      rnd_sat = {1'b1, {(gps_pkg::SON_W - 1){1'b0}}};
    end else begin
      rnd_sat = {1'b0, {(gps_pkg::SON_W - 1){1'b1}}};
    end
  endfunction

  logic en1, en2, en3;
  logic v1_q, v2_q, vo_q;

  logic signed [gps_pkg::PIX_W:0]      gx, gy;
  logic signed [2*gps_pkg::PIX_W+1:0]  gx2, gy2;
  logic [gps_pkg::SQ_W-1:0]            sq;
  logic                                sel;
  logic signed [gps_pkg::DP_W-1:0]     dxp_d, dyp_d;

  logic [gps_pkg::COL_W-1:0]           b1_col_q, b2_col_q;
  logic [gps_pkg::ROW_W-1:0]           b1_row_q, b2_row_q;
  logic [gps_pkg::PIX_W-1:0]           b1_gray_q, b2_gray_q;
  logic signed [gps_pkg::DP_W-1:0]     b1_dxp_q, b1_dyp_q;
  logic signed [gps_pkg::PROD_W-1:0]   p_cx_q, p_sy_q, p_cy_q, p_sx_q;
  logic signed [gps_pkg::SUM_W-1:0]    sx, sy;
  logic [gps_pkg::OUT_TDATA_W-1:0]     out_q;

  assign en3     = !vo_q || m_ready_i;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign q_pop_o = q_valid_i && en1;

  always_comb begin
    gx    = $signed({1'b0, q_data_i.right}) - $signed({1'b0, q_data_i.left});
    gy    = $signed({1'b0, q_data_i.below}) - $signed({1'b0, q_data_i.above});
    gx2   = gx * gx;
    gy2   = gy * gy;
    sq    = gps_pkg::SQ_W'(gx2) + gps_pkg::SQ_W'(gy2);
    sel   = (sq >= cfg_i.grad_thresh_sq);
    dxp_d = $signed(gps_pkg::DP_W'({q_data_i.col, 4'b0000}))
          - $signed(gps_pkg::DP_W'(cfg_i.offset_x));
    dyp_d = $signed(gps_pkg::DP_W'({q_data_i.row, 4'b0000}))
          - $signed(gps_pkg::DP_W'(cfg_i.offset_y));
  end

  always_comb begin
    sx = gps_pkg::SUM_W'(p_cx_q) + gps_pkg::SUM_W'(p_sy_q);
    sy = gps_pkg::SUM_W'(p_cy_q) - gps_pkg::SUM_W'(p_sx_q);
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      b1_col_q  <= q_data_i.col;
      b1_row_q  <= q_data_i.row;
      b1_gray_q <= q_data_i.gray;
      b1_dxp_q  <= dxp_d;
      b1_dyp_q  <= dyp_d;
    end
    if (en2) begin
      b2_col_q  <= b1_col_q;
      b2_row_q  <= b1_row_q;
      b2_gray_q <= b1_gray_q;
      p_cx_q    <= cfg_i.coef_cos * b1_dxp_q;
      p_sy_q    <= cfg_i.coef_sin * b1_dyp_q;
      p_cy_q    <= cfg_i.coef_cos * b1_dyp_q;
      p_sx_q    <= cfg_i.coef_sin * b1_dxp_q;
    end
    if (en3) begin
      out_q <= gps_pkg::OUT_TDATA_W'({rnd_sat(sy), rnd_sat(sx), b2_gray_q, b2_row_q,
                                      b2_col_q[gps_pkg::OCOL_W-1:0]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= q_valid_i && sel;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        vo_q <= v2_q;
      end
    end
  end

  assign m_valid_o = vo_q;
  assign m_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/gradient_pixel_select_to_sonar.sv =====
// Top level of the gradient point selector with pixel-to-sonar mapping.
//
// Pixels enter on the s_axis stream in raster order, one word per pixel; tuser
// flags the first pixel of a frame and resets the row and column counters.
// For each pixel arriving, the pixel one row above becomes the candidate; it is
// kept when it lies at least border_margin from every edge and dx^2 + dy^2
// reaches grad_thresh_sq. Kept pixels leave on m_axis in row-major order.
// Throughput is one pixel per clock while the candidate queue has room, set by
// the dual-read line buffer that returns the three neighbours in one access.
// A kept pixel goes through the front stage, the queue and the back-end pipeline.
// Registers are written through cfg_we_i/cfg_addr_i/cfg_wdata_i, by the user
// only while idle; the block does not enforce it. After reset the line buffers
// are cleared with s_axis_tready low; the registers return to their defaults.
// When m_axis stalls, results back up through the output pipeline and a
// four-entry candidate queue; s_axis_tready drops only once that queue fills.
`default_nettype none

module gradient_pixel_select_to_sonar #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [gps_pkg::CFG_AW-1:0]        cfg_addr_i,
  input  logic [gps_pkg::CFG_DW-1:0]        cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [gps_pkg::PIX_W-1:0]         s_axis_tdata,   // pixel
  input  logic                              s_axis_tuser,   // frame_start
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // col[9:0], row[21:10], gray[29:22], sonar_x[61:30], sonar_y[93:62], zero pad
  output logic [gps_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  gps_pkg::cfg_t   cfg_q, cfg_d;
  gps_pkg::cand_t  push_data, head_data;
  logic            q_push, q_full, q_valid, q_pop, clear_busy;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        gps_pkg::CFG_IMAGE_WIDTH:  cfg_d.image_width    = cfg_wdata_i[gps_pkg::IW_W-1:0];
        gps_pkg::CFG_IMAGE_HEIGHT: cfg_d.image_height   = cfg_wdata_i[gps_pkg::IH_W-1:0];
        gps_pkg::CFG_BORDER:       cfg_d.border_margin  = cfg_wdata_i[gps_pkg::BM_W-1:0];
        gps_pkg::CFG_THRESH:       cfg_d.grad_thresh_sq = cfg_wdata_i[gps_pkg::TH_W-1:0];
        gps_pkg::CFG_COEF_COS:     cfg_d.coef_cos       = $signed(cfg_wdata_i);
        gps_pkg::CFG_COEF_SIN:     cfg_d.coef_sin       = $signed(cfg_wdata_i);
        gps_pkg::CFG_OFFSET_X:     cfg_d.offset_x       = cfg_wdata_i[gps_pkg::OFS_W-1:0];
        gps_pkg::CFG_OFFSET_Y:     cfg_d.offset_y       = cfg_wdata_i[gps_pkg::OFS_W-1:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= gps_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  gps_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_pix_i      (s_axis_tdata),
    .s_fs_i       (s_axis_tuser),
    .q_push_o     (q_push),
    .q_data_o     (push_data),
    .q_full_i     (q_full),
    .clear_busy_o (clear_busy)
  );

  gps_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (push_data),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (head_data),
    .pop_i   (q_pop)
  );

  gps_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_data_i  (head_data),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata)
  );

`ifndef SYNTHESIS
  // margin of at least one keeps the top row out
  a_row_margin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[gps_pkg::OCOL_W +: gps_pkg::ROW_W] != '0))
    else $error("selected pixel on the top row");

  a_clear_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_busy |-> !s_axis_tready)
    else $error("pixel accepted during line buffer clear");

  a_queue_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("push into full candidate queue");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty candidate queue");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the gradient point selector with sonar mapping.
module tb;
  import gps_pkg::*;

  localparam int MAX_W       = 1024;
  localparam int RAND_PIXELS = 1100;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE      = 8;
  localparam int REG_BITS [8] = '{11, 12, 7, 17, 18, 18, 16, 16};

  // one outgoing word, col in the lowest bits as on m_axis_tdata
  typedef struct packed {
    logic signed [31:0] sy;
    logic signed [31:0] sx;
    logic [7:0]         gray;
    logic [11:0]        row;
    logic [9:0]         col;
  } sel_t;

  typedef enum logic {ROW_CFG, ROW_PIX} step_kind_e;
  typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_HIT} chk_e;

  typedef struct packed {
    step_kind_e         kind;
    cfg_idx_e           idx;
    logic [CFG_DW-1:0]  val;
    logic [7:0]         pix;
    logic               fs;
    chk_e               chk;
    sel_t               want;
  } plan_row_t;

  localparam sel_t NO_SEL  = '0;
  localparam sel_t HIT_MID = '{sy: 32'sd0, sx: 32'sd0, gray: 8'hFF, row: 12'd1, col: 10'd1};

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_AW-1:0]      cfg_addr_i = CFG_IMAGE_WIDTH;
  logic [CFG_DW-1:0]      cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [PIX_W-1:0]       s_axis_tdata = '0;    // pixel
  logic                   s_axis_tuser = 1'b0;  // frame_start
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // col[9:0], row[21:10], gray[29:22], sonar_x[61:30], sonar_y[93:62], zero pad
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  gradient_pixel_select_to_sonar #(
    .MAX_WIDTH(MAX_W)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow registers
  logic [10:0]        cfg_w   = 11'd640;
  logic [11:0]        cfg_h   = 12'd480;
  logic [6:0]         cfg_m   = 7'd10;
  logic [16:0]        cfg_th  = 17'd10000;
  logic signed [17:0] cfg_cos = 18'sd0;
  logic signed [17:0] cfg_sin = -18'sd1311;
  logic [15:0]        cfg_ox  = 16'd5120;
  logic [15:0]        cfg_oy  = 16'd7680;

  // selector state
  logic [7:0] line_prev [MAX_W];
  logic [7:0] line_cur  [MAX_W];
  logic [7:0] win_mid;
  int         col_pos;
  int         row_pos;

  sel_t sel_due [$];
  sel_t got_sel;
  sel_t want_sel;
  int   mismatches = 0;
  int   n_sent = 0;
  int   cycles = 0;
  bit   steady = 1'b0;

  function automatic logic signed [31:0] round_q16(input longint v);
    longint q;
    q = (v + 8) >>> 4;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  // advances the selector by one pixel; returns 1 when the candidate above is kept
  function automatic bit score_pixel(input logic [7:0] pix, input logic fs, output sel_t res);
    longint     w, h, m, x, y, gx, gy, sq, dxp, dyp;
    int         c;
    logic [7:0] above2, mid, right_nb, left_nb;
    bit         hit;
    w = (cfg_w == 0) ? 1 : ((cfg_w > MAX_W) ? MAX_W : cfg_w);
    h = (cfg_h == 0) ? 1 : cfg_h;
    m = (cfg_m == 0) ? 1 : cfg_m;
    hit = 1'b0;
    res = '0;
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) col_pos = 0;
    c = col_pos % MAX_W;
    above2 = line_prev[c];
    mid = line_cur[c];
    right_nb = (c + 1 < MAX_W) ? line_cur[c + 1] : 8'h00;
    // left neighbour of the row above was latched one pixel ago
    left_nb = win_mid;
    win_mid = mid;
    x = c;
    y = row_pos - 1;
    if (y >= m && y + m < h && x >= m && x + m < w) begin
      gx = longint'(right_nb) - longint'(left_nb);
      gy = longint'(pix) - longint'(above2);
      sq = gx * gx + gy * gy;
      if (sq >= longint'(cfg_th)) begin
        dxp = x * 16 - longint'(cfg_ox);
        dyp = y * 16 - longint'(cfg_oy);
        res.col = x[9:0];
        res.row = y[11:0];
        res.gray = mid;
        res.sx = round_q16(longint'(cfg_cos) * dxp + longint'(cfg_sin) * dyp);
        res.sy = round_q16(longint'(cfg_cos) * dyp - longint'(cfg_sin) * dxp);
        hit = 1'b1;
      end
    end
    line_prev[c] = mid;
    line_cur[c] = pix;
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = row_pos + 1;
      if (row_pos >= h) row_pos = 0;
    end
    row_pos = row_pos & 'hFFF;
    return hit;
  endfunction

  task automatic cfg_write(input cfg_idx_e idx, input logic [CFG_DW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH:  cfg_w = val[10:0];
      CFG_IMAGE_HEIGHT: cfg_h = val[11:0];
      CFG_BORDER:       cfg_m = val[6:0];
      CFG_THRESH:       cfg_th = val[16:0];
      CFG_COEF_COS:     cfg_cos = val[17:0];
      CFG_COEF_SIN:     cfg_sin = val[17:0];
      CFG_OFFSET_X:     cfg_ox = val[15:0];
      CFG_OFFSET_Y:     cfg_oy = val[15:0];
      default: ;
    endcase
  endtask

  task automatic send_pixel(input logic [7:0] pix, input logic fs, input chk_e chk,
                            input sel_t want);
    int   gap;
    int   r;
    sel_t res;
    bit   hit;
    r = $urandom_range(0, 99);
    gap = (steady || r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= pix;
    s_axis_tuser <= fs;
    do @(posedge clk_i); while (!s_axis_tready);
    hit = score_pixel(pix, fs, res);
    if (chk == CHK_HIT) sel_due.insert(sel_due.size(), want);
    else if (chk == CHK_PRED && hit) sel_due.insert(sel_due.size(), res);
    n_sent++;
  endtask

  // stop sending until every expected word is out, then let the pipe settle
  task automatic drain(input int tail);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sel_due.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_sel = m_axis_tdata[OUT_W-1:0];
      if (sel_due.size() == 0) begin
        $error("unexpected result word: col %0d row %0d", got_sel.col, got_sel.row);
        mismatches++;
      end else begin
        want_sel = sel_due.pop_front();
        if (got_sel.col !== want_sel.col) begin
          $error("col: expected %0d, got %0d", want_sel.col, got_sel.col);
          mismatches++;
        end
        if (got_sel.row !== want_sel.row) begin
          $error("row: expected %0d, got %0d", want_sel.row, got_sel.row);
          mismatches++;
        end
        if (got_sel.gray !== want_sel.gray) begin
          $error("gray: expected %0d, got %0d", want_sel.gray, got_sel.gray);
          mismatches++;
        end
        if (got_sel.sx !== want_sel.sx) begin
          $error("sonar_x: expected %0d, got %0d", want_sel.sx, got_sel.sx);
          mismatches++;
        end
        if (got_sel.sy !== want_sel.sy) begin
          $error("sonar_y: expected %0d, got %0d", want_sel.sy, got_sel.sy);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: bursts of ready with short stalls, the odd long one
  initial begin
    int run;
    int stall;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 8);
      stall = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 3);
      repeat (run) @(negedge clk_i) m_axis_tready <= 1'b1;
      repeat (stall) @(negedge clk_i) m_axis_tready <= 1'b0;
    end
  end

  initial begin
    plan_row_t        plan [29];
    int               k, f, i, npix, mid_fs, nfr, pick, style, weff, heff;
    bit               first, skip_fs;
    logic [CFG_DW-1:0] v;
    logic [7:0]       pix, base;

    // 3x3 frame, everything interior kept, zero mapping; then the steepest gradient
    // exactly at the top threshold on a frame that follows without frame_start
    plan = '{
      '{ROW_CFG, CFG_IMAGE_WIDTH,  18'd3,      8'h00, 1'b0, CHK_PRED, NO_SEL},
      '{ROW_CFG, CFG_IMAGE_HEIGHT, 18'd3,      8'h00, 1'b0, CHK_PRED, NO_SEL},
      '{ROW_CFG, CFG_BORDER,       18'd1,      8'h00, 1'b0, CHK_PRED, NO_SEL},
      '{ROW_CFG, CFG_THRESH,       18'd0,      8'h00, 1'b0, CHK_PRED, NO_SEL},
      '{ROW_CFG, CFG_COEF_COS,     18'd0,      8'h00, 1'b0, CHK_PRED, NO_SEL},
      '{ROW_CFG, CFG_COEF_SIN,     18'd0,      8'h00, 1'b0, CHK_PRED, NO_SEL},
      '{ROW_PIX, CFG_IMAGE_WIDTH,  18'd0,      8'h00, 1'b1, CHK_NONE, NO_SEL},
      '{ROW_PIX, CFG_IMAGE_WIDTH,  18'd0,      8'hFF, 1'b0, CHK_NONE, NO_SEL},
      '{ROW_PIX, CFG_IMAGE_WIDTH,  18'd0,      8'h80, 1'b0, CHK_NONE, NO_SEL},
      '{ROW_PIX, CFG_IMAGE_WIDTH,  18'd0,      8'h7F, 1'b0, CHK_NONE, NO_SEL},
      '{ROW_PIX, CFG_IMAGE_WIDTH,  18'd0,      8'hFF, 1'b0, CHK_NONE, NO_SEL},
      '{ROW_PIX, CFG_IMAGE_WIDTH,  18'd0,      8'h01, 1'b0, CHK_NONE, NO_SEL},
      '{ROW_PIX, CFG_IMAGE_WIDTH,  18'd0,      8'h55, 1'b0, CHK_NONE, NO_SEL},
      '{ROW_PIX, CFG_IMAGE_WIDTH,  18'd0,      8'hAA, 1'b0, CHK_HIT,  HIT_MID},
      '{ROW_PIX, CFG_IMAGE_WIDTH,  18'd0,      8'h00, 1'b0, CHK_NONE, NO_SEL},
      '{ROW_CFG, CFG_THRESH,       18'd130050, 8'h00, 1'b0, CHK_PRED, NO_SEL},
      '{ROW_CFG, CFG_COEF_COS,     18'h1FFFF,  8'h00, 1'b0, CHK_PRED, NO_SEL},
      '{ROW_CFG, CFG_COEF_SIN,     18'h20000,  8'h00, 1'b0, CHK_PRED, NO_SEL},
      '{ROW_CFG, CFG_OFFSET_X,     18'h0FFFF,  8'h00, 1'b0, CHK_PRED, NO_SEL},
      '{ROW_CFG, CFG_OFFSET_Y,     18'd0,      8'h00, 1'b0, CHK_PRED, NO_SEL},
      '{ROW_PIX, CFG_IMAGE_WIDTH,  18'd0,      8'h00, 1'b0, CHK_PRED, NO_SEL},
      '{ROW_PIX, CFG_IMAGE_WIDTH,  18'd0,      8'h00, 1'b0, CHK_PRED, NO_SEL},
      '{ROW_PIX, CFG_IMAGE_WIDTH,  18'd0,      8'h00, 1'b0, CHK_PRED, NO_SEL},
      '{ROW_PIX, CFG_IMAGE_WIDTH,  18'd0,      8'h00, 1'b0, CHK_PRED, NO_SEL},
      '{ROW_PIX, CFG_IMAGE_WIDTH,  18'd0,      8'h5A, 1'b0, CHK_PRED, NO_SEL},
      '{ROW_PIX, CFG_IMAGE_WIDTH,  18'd0,      8'hFF, 1'b0, CHK_PRED, NO_SEL},
      '{ROW_PIX, CFG_IMAGE_WIDTH,  18'd0,      8'h00, 1'b0, CHK_PRED, NO_SEL},
      '{ROW_PIX, CFG_IMAGE_WIDTH,  18'd0,      8'hFF, 1'b0, CHK_PRED, NO_SEL},
      '{ROW_PIX, CFG_IMAGE_WIDTH,  18'd0,      8'h00, 1'b0, CHK_PRED, NO_SEL}
    };

    for (k = 0; k < MAX_W; k++) begin
      line_prev[k] = 8'h00;
      line_cur[k] = 8'h00;
    end
    win_mid = 8'h00;
    col_pos = 0;
    row_pos = 0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    // line buffers are cleared before the first pixel is taken
    do @(posedge clk_i); while (!s_axis_tready);

    foreach (plan[j]) begin
      if (plan[j].kind == ROW_CFG) begin
        drain(SETTLE);
        cfg_write(plan[j].idx, plan[j].val);
      end else begin
        send_pixel(plan[j].pix, plan[j].fs, plan[j].chk, plan[j].want);
      end
    end

    first = 1'b1;
    while (n_sent < RAND_PIXELS) begin
      drain(SETTLE);
      steady = ($urandom_range(0, 3) == 0);
      for (k = 0; k < 8; k++) begin
        if (first || $urandom_range(0, 1) == 1) begin
          pick = $urandom_range(0, 9);
          case (cfg_idx_e'(k)) inside
            CFG_IMAGE_WIDTH:
              v = (pick < 3) ? 18'(pick) :
                  (pick == 3) ? 18'($urandom_range(15, 40)) : 18'($urandom_range(3, 12));
            CFG_IMAGE_HEIGHT:
              v = (pick < 3) ? 18'(pick) :
                  (pick == 3) ? 18'd4095 : 18'($urandom_range(3, 10));
            CFG_BORDER:
              v = (pick == 0) ? 18'd0 : (pick == 1) ? 18'd64 :
                  (pick == 2) ? 18'($urandom_range(65, 127)) : (pick == 3) ? 18'd2 : 18'd1;
            CFG_THRESH:
              v = (pick == 0) ? 18'd0 : (pick == 1) ? 18'd130050 :
                  (pick == 2) ? 18'($urandom_range(130051, 131071)) :
                  (pick == 3) ? 18'($urandom_range(0, 130050)) : 18'($urandom_range(0, 3000));
            CFG_COEF_COS, CFG_COEF_SIN:
              v = (pick == 0) ? 18'h1FFFF : (pick == 1) ? 18'h20000 :
                  (pick == 2) ? 18'd0 : 18'($urandom);
            default:
              v = (pick == 0) ? 18'd0 : (pick == 1) ? 18'h0FFFF : 18'($urandom_range(0, 65535));
          endcase
          // junk above the register width must be ignored
          if ($urandom_range(0, 3) == 0)
            v = v | (18'($urandom) & ~((18'd1 << REG_BITS[k]) - 18'd1));
          cfg_write(cfg_idx_e'(k), v);
        end
      end
      first = 1'b0;
      weff = (cfg_w == 0) ? 1 : ((cfg_w > MAX_W) ? MAX_W : cfg_w);
      heff = (cfg_h == 0) ? 1 : cfg_h;
      nfr = $urandom_range(1, 3);
      for (f = 0; f < nfr; f++) begin
        npix = weff * heff;
        if (npix > 240) npix = $urandom_range(100, 240);
        if ($urandom_range(0, 9) == 0) npix = $urandom_range(1, npix);
        mid_fs = ($urandom_range(0, 11) == 0) ? $urandom_range(1, npix) : -1;
        skip_fs = ($urandom_range(0, 7) == 0);
        style = $urandom_range(0, 3);
        base = 8'($urandom);
        for (i = 0; i < npix; i++) begin
          case (style)
            0:       pix = 8'($urandom);
            1:       pix = base ^ 8'($urandom_range(0, 7));
            2:       pix = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            default: pix = 8'(base + i * 7);
          endcase
          if ($urandom_range(0, 299) == 0) drain(0);
          send_pixel(pix, logic'((i == 0 && !skip_fs) || i == mid_fs), CHK_PRED, NO_SEL);
        end
      end
    end

    drain(SETTLE);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/gps_pkg.sv
rtl/gps_front.sv
rtl/gps_queue.sv
rtl/gps_back.sv
rtl/gradient_pixel_select_to_sonar.sv
tb/sv/tb.sv
